/* design/tgl_pkg.sv */
// ----------------------------------------------------------------------------
// Text glyph layout package
// Shared types, command and character codes, palette tables and the
// saturating helpers used by the layout datapath.
// ----------------------------------------------------------------------------
package tgl_pkg;

    // Item kinds carried on the slave-side tuser.
    localparam logic [1:0] CMD_WIDTH = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TEXT  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_LINE_HEIGHT = 1'b0;
    localparam logic REG_ANAGLYPH    = 1'b1;

    // Special text bytes.
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_ESCAPE  = 8'ha7;

    localparam logic [7:0]  LINE_HEIGHT_RESET = 8'd10;
    localparam logic [7:0]  ALPHA_OPAQUE      = 8'hff;
    localparam logic [14:0] PEN_MAX           = 15'h7fff;

    // The sixteen palette colors as 0xRRGGBB, plain and anaglyph-mixed.
    localparam logic [23:0] PALETTE [16] = '{
        24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
        24'haa0000, 24'haa00aa, 24'hffaa00, 24'haaaaaa,
        24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
        24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff
    };

    // Grey-weighted mix: r' = .30r+.59g+.11b, g' = .30r+.70g, b' = .30r+.70b,
    // rounded down.
    localparam logic [23:0] PALETTE_ANAGLYPH [16] = '{
        24'h000000, 24'h120077, 24'h647700, 24'h777777,
        24'h333333, 24'h4533aa, 24'hb0c34c, 24'haaaaaa,
        24'h555555, 24'h6755cc, 24'hb9cc55, 24'hcccccc,
        24'h888888, 24'h9a88ff, 24'hecff88, 24'hffffff
    };

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         code;
        logic [31:0]        base_color;
        logic               darken;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
    } tgl_item_t;

    typedef struct packed {
        logic       wr;
        logic       rd;
        logic [7:0] addr;
        logic [3:0] data;
    } tgl_mem_req_t;

    // Pen offset plus an advance, held at the largest positive offset.
    function automatic logic [14:0] pen_add(input logic [14:0] pen, input logic [7:0] step);
        logic [15:0] sum;
        sum = {1'b0, pen} + {8'd0, step};
        return sum[15] ? PEN_MAX : sum[14:0];
    endfunction

    // Origin plus pen offset, saturated to the signed 16-bit range.
    function automatic logic [15:0] pos_sat(input logic signed [15:0] origin,
                                            input logic [14:0] pen);
        logic signed [16:0] sum;
        sum = {origin[15], origin} + $signed({2'b00, pen});
        if (sum[16] != sum[15])
        begin
            return sum[16] ? 16'h8000 : 16'h7fff;
        end
        return sum[15:0];
    endfunction

endpackage

/* design/tgl_adv_mem.sv */
// ----------------------------------------------------------------------------
// Advance table
// Per-character advance widths in a single-port memory with registered read.
// Each entry has a valid bit cleared at reset, so unwritten entries read zero.
// ----------------------------------------------------------------------------
module tgl_adv_mem #(
    parameter int GLYPH_COUNT = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tgl_pkg::tgl_mem_req_t req,
    output logic [3:0]            rd_data
);
    import tgl_pkg::*;

    localparam int         IDX_W     = $clog2(GLYPH_COUNT);
    localparam logic [8:0] COUNT_LIM = 9'(GLYPH_COUNT);

    logic [3:0]             mem [GLYPH_COUNT];
    logic [GLYPH_COUNT-1:0] valid_reg;
    logic [3:0]             rd_data_reg;
    logic [IDX_W-1:0]       idx;
    logic                   in_range;

    assign idx      = req.addr[IDX_W-1:0];
    assign in_range = {1'b0, req.addr} < COUNT_LIM;
    assign rd_data  = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr && in_range)
        begin
            valid_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr && in_range)
        begin
            mem[idx] <= req.data;
        end
        if (req.rd)
        begin
            // Codes past the table and entries never written advance by zero.
            rd_data_reg <= (in_range && valid_reg[idx]) ? mem[idx] : 4'd0;
        end
    end

endmodule

/* design/tgl_palette.sv */
// ----------------------------------------------------------------------------
// Palette selector
// Decodes the hex digit after an escape byte into one of sixteen colors,
// with optional anaglyph mixing and quartering for the shadow pass.
// ----------------------------------------------------------------------------
module tgl_palette (
    input  logic [7:0]  digit,
    input  logic        anaglyph,
    input  logic        darken,
    output logic [23:0] rgb
);
    import tgl_pkg::*;

    logic [3:0]  color_idx;
    logic [23:0] base;

    always_comb
    begin
        case (digit) inside
            [8'h30:8'h39]:              color_idx = digit[3:0];
            [8'h41:8'h46], [8'h61:8'h66]: color_idx = digit[3:0] + 4'd9;
            default:                    color_idx = 4'd15;
        endcase
    end

    assign base = anaglyph ? PALETTE_ANAGLYPH[color_idx] : PALETTE[color_idx];

    assign rgb = darken ? {2'b00, base[23:18], 2'b00, base[15:10], 2'b00, base[7:2]}
                        : base;

endmodule

/* design/text_glyph_layout_engine.sv */
// ----------------------------------------------------------------------------
// Text glyph layout engine
// Turns a stream of text commands into glyph placements with color.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the slave stream; s_tuser gives the command (width entry,
//   start string, text byte). Start commands latch origin, color and darken;
//   width commands fill the advance table; text bytes produce one glyph item
//   on the master stream unless they are NUL, newline, the escape byte or the
//   digit after an escape.
//   Throughput is one item per cycle while the receiver does not stall. An
//   accepted item sits in the input register, is processed into the result
//   register when that register can take it, and its glyph then shows on
//   m_tvalid. The advance table read is issued at acceptance so its
//   registered data lines up with the item. When the receiver stalls, the
//   result register holds and the input register takes one more item;
//   s_tready then drops until the result register drains. The user must write
//   configuration through cfg_we only while idle; the block does not enforce it.
//   Reset clears the pen, origin, color, escape state and all advance
//   entries (valid bits), and sets alpha to opaque and line height to ten.
// ----------------------------------------------------------------------------
module text_glyph_layout_engine #(
    parameter int GLYPH_COUNT = 256,
    parameter int CELL_SIZE   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata, low bit up: code_byte[8], width_value[4], base_color[32],
    // darken[1], origin_x[16], origin_y[16], zero fill[3]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    // s_tuser: command[2]
    input  logic [1:0]  s_tuser,
    // m_tdata, low bit up: glyph_code[8], pos_x[16], pos_y[16], atlas_u[7],
    // atlas_v[7], red[8], green[8], blue[8], alpha[8], zero fill[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import tgl_pkg::*;

    localparam int PROD_W = 4 + $clog2(CELL_SIZE + 1);

    tgl_item_t    item_in;
    tgl_item_t    item_reg;
    tgl_mem_req_t mem_req;
    logic         in_valid_reg;
    logic         accept;
    logic         advance;
    logic [3:0]   adv_width;
    logic [23:0]  pal_rgb;

    logic [7:0]         line_height_reg;
    logic               anaglyph_reg;
    logic [14:0]        pen_x_reg, pen_x_next;
    logic [14:0]        pen_y_reg, pen_y_next;
    logic signed [15:0] start_x_reg, start_x_next;
    logic signed [15:0] start_y_reg, start_y_next;
    logic [23:0]        rgb_reg, rgb_next;
    logic [7:0]         alpha_reg, alpha_next;
    logic               darken_reg, darken_next;
    logic               escape_reg, escape_next;
    logic               glyph;

    logic               m_tvalid_reg;
    logic [87:0]        m_tdata_reg;
    logic [87:0]        m_tdata_next;
    logic [PROD_W-1:0]  atlas_u_full;
    logic [PROD_W-1:0]  atlas_v_full;

    assign item_in.cmd        = s_tuser;
    assign item_in.code       = s_tdata[7:0];
    assign item_in.base_color = s_tdata[43:12];
    assign item_in.darken     = s_tdata[44];
    assign item_in.origin_x   = s_tdata[60:45];
    assign item_in.origin_y   = s_tdata[76:61];

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Table writes and reads happen in acceptance order, so a width entry is
    // always visible to any text byte that follows it.
    assign mem_req.wr   = accept && (s_tuser == CMD_WIDTH);
    assign mem_req.rd   = accept && (s_tuser == CMD_TEXT);
    assign mem_req.addr = s_tdata[7:0];
    assign mem_req.data = s_tdata[11:8];

    tgl_adv_mem #(
        .GLYPH_COUNT(GLYPH_COUNT)
    ) u_adv_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (adv_width)
    );

    tgl_palette u_palette (
        .digit    (item_reg.code),
        .anaglyph (anaglyph_reg),
        .darken   (darken_reg),
        .rgb      (pal_rgb)
    );

    always_comb
    begin
        pen_x_next   = pen_x_reg;
        pen_y_next   = pen_y_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        rgb_next     = rgb_reg;
        alpha_next   = alpha_reg;
        darken_next  = darken_reg;
        escape_next  = escape_reg;
        glyph        = 1'b0;
        if (advance)
        begin
            case (item_reg.cmd)
                CMD_START:
                begin
                    darken_next  = item_reg.darken;
                    rgb_next     = item_reg.darken
                        ? {2'b00, item_reg.base_color[23:18], 2'b00,
                           item_reg.base_color[15:10], 2'b00, item_reg.base_color[7:2]}
                        : item_reg.base_color[23:0];
                    alpha_next   = (item_reg.base_color[31:24] == 8'd0)
                        ? ALPHA_OPAQUE : item_reg.base_color[31:24];
                    start_x_next = item_reg.origin_x;
                    start_y_next = item_reg.origin_y;
                    pen_x_next   = '0;
                    pen_y_next   = '0;
                    escape_next  = 1'b0;
                end
                CMD_TEXT:
                begin
                    if (escape_reg)
                    begin
                        escape_next = 1'b0;
                        rgb_next    = pal_rgb;
                    end
                    else if (item_reg.code == CHAR_NUL)
                    begin
                        escape_next = 1'b0;
                    end
                    else if (item_reg.code == CHAR_ESCAPE)
                    begin
                        escape_next = 1'b1;
                    end
                    else if (item_reg.code == CHAR_NEWLINE)
                    begin
                        pen_x_next = '0;
                        pen_y_next = pen_add(pen_y_reg, line_height_reg);
                    end
                    else
                    begin
                        glyph      = 1'b1;
                        pen_x_next = pen_add(pen_x_reg, {4'd0, adv_width});
                    end
                end
                default:
                begin
                    glyph = 1'b0;
                end
            endcase
        end
    end

    assign atlas_u_full = PROD_W'(item_reg.code[3:0]) * PROD_W'(CELL_SIZE);
    assign atlas_v_full = PROD_W'(item_reg.code[7:4]) * PROD_W'(CELL_SIZE);

    assign m_tdata_next = {2'b00, alpha_reg, rgb_reg[7:0], rgb_reg[15:8], rgb_reg[23:16],
                           atlas_v_full[6:0], atlas_u_full[6:0],
                           pos_sat(start_y_reg, pen_y_reg),
                           pos_sat(start_x_reg, pen_x_reg),
                           item_reg.code};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            line_height_reg <= LINE_HEIGHT_RESET;
            anaglyph_reg    <= 1'b0;
            pen_x_reg       <= '0;
            pen_y_reg       <= '0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            rgb_reg         <= '0;
            alpha_reg       <= ALPHA_OPAQUE;
            darken_reg      <= 1'b0;
            escape_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                m_tvalid_reg <= glyph;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LINE_HEIGHT: line_height_reg <= cfg_data;
                    REG_ANAGLYPH:    anaglyph_reg    <= cfg_data[0];
                    default:         anaglyph_reg    <= anaglyph_reg;
                endcase
            end

            pen_x_reg   <= pen_x_next;
            pen_y_reg   <= pen_y_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            rgb_reg     <= rgb_next;
            alpha_reg   <= alpha_next;
            darken_reg  <= darken_next;
            escape_reg  <= escape_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
        if (glyph)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* design/tgl_checker.sv */
// ----------------------------------------------------------------------------
// Text glyph layout port checker
// Watches the top-level ports for stream stability and for glyph items that
// the layout rules can never produce.
// ----------------------------------------------------------------------------
module tgl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);
    import tgl_pkg::*;

    // A stalled result item stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item withdrawn while stalled");

    // A stalled result item keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // An output that appears from empty comes from an item taken in through the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result item without a matching input item");

    // Control bytes never become glyphs, and alpha is never transparent.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] != CHAR_NUL) && (m_tdata[7:0] != CHAR_NEWLINE)
                     && (m_tdata[7:0] != CHAR_ESCAPE) && (m_tdata[85:78] != 8'h00))
        else $error("glyph item with a control code or zero alpha");

endmodule

bind text_glyph_layout_engine tgl_checker u_tgl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
